// ----- hdl/ncc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types, opcodes and the control store of the collider check sequencer.
// ----------------------------------------------------------------------------
package ncc_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // sequencer steps
    typedef enum logic [1:0] {
        U_ACCEPT,
        U_LOAD,
        U_SWEEP,
        U_EMIT
    } t_upc;

    // jump conditions; the jump is taken when true, else the step holds
    typedef enum logic [1:0] {
        C_ALWAYS,
        C_QUERY,
        C_LAST,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic  ready;
        logic  load;
        logic  sweep;
        logic  emit;
        t_cond cond;
        t_upc  target;
    } t_uword;

    function automatic t_uword f_ucode(input t_upc pc);
        t_uword w;
        w = '0;
        unique case (pc)
            U_ACCEPT: begin
                w.ready  = 1'b1;
                w.cond   = C_QUERY;
                w.target = U_LOAD;
            end
            U_LOAD: begin
                w.load   = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = U_SWEEP;
            end
            U_SWEEP: begin
                w.sweep  = 1'b1;
                w.cond   = C_LAST;
                w.target = U_EMIT;
            end
            U_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = C_OUT_FREE;
                w.target = U_ACCEPT;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/new_collider_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// new_collider_check
// Adjacency store and new collider test for one node of a partially directed
// graph, run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// The block holds an adjacency matrix of min(NODES,32) nodes, kept as rows and
// as a transposed copy in flip-flops, both cleared by reset. A write item
// (opcode 0) replaces one row; rows at or above NODES are ignored. A query
// item (opcode 1) goes through the steps accept, load of the row and column
// of the target node, a sweep of the matrix one row per cycle, and emit, which
// hands the item to the output register. The sweep, one row read per cycle,
// sets the query time. A finished item waits in the output register while the
// next input item is accepted; the sequencer only stalls in its last step if
// that register is still full.
module new_collider_check #(
    parameter int NODES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_opcode,
    input  logic [4:0]  i_node,
    input  logic [31:0] i_row_bits,
    input  logic [31:0] i_partition,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_unique_parents,
    output logic [31:0] o_ambiguous_parents,
    output logic [5:0]  o_ambiguous_count,
    output logic        o_collider_first,
    output logic        o_collider_second
);

    localparam int ROWS = (NODES < 32) ? NODES : 32;
    localparam int IW   = $clog2(ROWS);
    localparam logic [IW-1:0] LAST    = IW'(ROWS - 1);
    localparam logic [5:0]    MAX_ROW = 6'(ROWS);

    typedef logic [ROWS-1:0] t_row;

    // adjacency rows and transposed copy
    t_row r_adj  [ROWS];
    t_row r_adjt [ROWS];

    ncc_pkg::t_upc   r_step, n_step;
    ncc_pkg::t_uword uw;

    logic [4:0]    r_node, n_node;
    logic [31:0]   r_part, n_part;
    logic [IW-1:0] r_j, n_j;
    t_row          r_r, n_r;
    t_row          r_c, n_c;
    t_row          r_first, n_first;
    t_row          r_second, n_second;
    t_row          r_hf, n_hf;
    t_row          r_hs, n_hs;
    logic [5:0]    r_cnt, n_cnt;
    logic          r_c1f, n_c1f;
    logic          r_c1s, n_c1s;

    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_o_uniq, n_o_uniq;
    logic [31:0]   r_o_amb, n_o_amb;
    logic [5:0]    r_o_cnt, n_o_cnt;
    logic          r_o_cf, n_o_cf;
    logic          r_o_cs, n_o_cs;

    logic          in_fire;
    logic          out_free;
    logic          take;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [IW-1:0] x_idx;
    logic          x_in_range;
    t_row          uniq;
    t_row          row_j;
    t_row          col_j;
    t_row          sym_j;
    t_row          oneway_j;
    t_row          jbit;
    t_row          xbit;
    t_row          far_x;
    logic          amb_j;

    assign uw         = ncc_pkg::f_ucode(r_step);
    assign o_in_ready = uw.ready;
    assign in_fire    = i_in_valid & uw.ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    assign wr_idx     = i_node[IW-1:0];
    assign wr_en      = in_fire && (i_opcode == ncc_pkg::OP_WRITE)
                        && ({1'b0, i_node} < MAX_ROW);
    assign x_idx      = r_node[IW-1:0];
    assign x_in_range = {1'b0, r_node} < MAX_ROW;

    assign uniq     = r_r & ~r_c;
    assign row_j    = r_adj[r_j];
    assign col_j    = r_adjt[r_j];
    assign sym_j    = row_j | col_j;
    assign oneway_j = row_j & ~col_j;
    assign jbit     = t_row'(1) << r_j;
    assign amb_j    = r_r[r_j] & r_c[r_j];

    always_comb begin
        for (int k = 0; k < ROWS; k++) begin
            xbit[k] = (r_node == 5'(k));
        end
    end

    // nodes other than x that are not adjacent to x
    assign far_x = ~(r_r | r_c) & ~xbit;

    // adjacency store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROWS; k++) begin
                r_adj[k]  <= '0;
                r_adjt[k] <= '0;
            end
        end else if (wr_en) begin
            r_adj[wr_idx] <= i_row_bits[ROWS-1:0];
            for (int k = 0; k < ROWS; k++) begin
                r_adjt[k][wr_idx] <= i_row_bits[k];
            end
        end
    end

    // sequencer step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ncc_pkg::U_ACCEPT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        case (uw.cond)
            ncc_pkg::C_ALWAYS:   take = 1'b1;
            ncc_pkg::C_QUERY:    take = in_fire && (i_opcode == ncc_pkg::OP_QUERY);
            ncc_pkg::C_LAST:     take = (r_j == LAST);
            ncc_pkg::C_OUT_FREE: take = out_free;
            default:             take = 1'b0;
        endcase
        n_step = take ? uw.target : r_step;
    end

    // datapath
    always_comb begin
        n_node   = r_node;
        n_part   = r_part;
        n_j      = r_j;
        n_r      = r_r;
        n_c      = r_c;
        n_first  = r_first;
        n_second = r_second;
        n_hf     = r_hf;
        n_hs     = r_hs;
        n_cnt    = r_cnt;
        n_c1f    = r_c1f;
        n_c1s    = r_c1s;

        if (in_fire) begin
            n_node = i_node;
            n_part = i_partition;
        end

        if (uw.load) begin
            n_r      = x_in_range ? r_adj[x_idx] : '0;
            n_c      = x_in_range ? r_adjt[x_idx] : '0;
            n_j      = '0;
            n_first  = '0;
            n_second = '0;
            n_hf     = '0;
            n_hs     = '0;
            n_cnt    = '0;
            n_c1f    = 1'b0;
            n_c1s    = 1'b0;
        end

        if (uw.sweep) begin
            n_j = (r_j == LAST) ? r_j : r_j + 1'b1;
            if (amb_j) begin
                n_part = {1'b0, r_part[31:1]};
                n_cnt  = r_cnt + 1'b1;
                if (r_part[0]) begin
                    n_c1f   = r_c1f | (|((uniq | r_first) & ~sym_j));
                    n_first = r_first | jbit;
                    n_hs    = r_hs | oneway_j;
                end else begin
                    n_c1s    = r_c1s | (|((uniq | r_second) & ~sym_j));
                    n_second = r_second | jbit;
                    n_hf     = r_hf | oneway_j;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j      <= '0;
            r_r      <= '0;
            r_c      <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_hf     <= '0;
            r_hs     <= '0;
            r_cnt    <= '0;
            r_c1f    <= 1'b0;
            r_c1s    <= 1'b0;
        end else begin
            r_j      <= n_j;
            r_r      <= n_r;
            r_c      <= n_c;
            r_first  <= n_first;
            r_second <= n_second;
            r_hf     <= n_hf;
            r_hs     <= n_hs;
            r_cnt    <= n_cnt;
            r_c1f    <= n_c1f;
            r_c1s    <= n_c1s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_part <= n_part;
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid & ~i_out_ready;
        n_o_uniq    = r_o_uniq;
        n_o_amb     = r_o_amb;
        n_o_cnt     = r_o_cnt;
        n_o_cf      = r_o_cf;
        n_o_cs      = r_o_cs;
        if (uw.emit && out_free) begin
            n_out_valid = 1'b1;
            n_o_uniq    = 32'(uniq);
            n_o_amb     = 32'(r_r & r_c);
            n_o_cnt     = r_cnt;
            n_o_cf      = r_c1f | (|(r_hf & far_x));
            n_o_cs      = r_c1s | (|(r_hs & far_x));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_uniq <= n_o_uniq;
        r_o_amb  <= n_o_amb;
        r_o_cnt  <= n_o_cnt;
        r_o_cf   <= n_o_cf;
        r_o_cs   <= n_o_cs;
    end

    assign o_out_valid         = r_out_valid;
    assign o_unique_parents    = r_o_uniq;
    assign o_ambiguous_parents = r_o_amb;
    assign o_ambiguous_count   = r_o_cnt;
    assign o_collider_first    = r_o_cf;
    assign o_collider_second   = r_o_cs;

`ifndef NO_ASSERTIONS
    a_sweep_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == ncc_pkg::U_SWEEP && r_j != LAST)
        |=> (r_step == ncc_pkg::U_SWEEP && r_j == $past(r_j) + 1'b1))
        else $error("sweep did not advance by one row");

    a_sets_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_first & r_second) == '0) && (((r_first | r_second) & ~(r_r & r_c)) == '0))
        else $error("partition sets overlap or hold a non-ambiguous node");

    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 6'($countones(r_first | r_second)))
        else $error("ambiguous count disagrees with partition sets");

    a_query_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_opcode == ncc_pkg::OP_QUERY) |=> (r_step == ncc_pkg::U_LOAD))
        else $error("accepted query item did not start a load");
`endif

endmodule
